[rtl/core/dnd_pkg.sv]
// Shared types and constants for the DNS name decompressor.
`default_nettype none

package dnd_pkg;

  // Packet store geometry
  localparam int          ADDR_W       = 9;
  localparam int          PACKET_BYTES = 1 << ADDR_W;

  // Byte codes
  localparam logic [7:0]  PTR_MARK     = 8'hC0;
  localparam logic [7:0]  DOT_CHAR     = 8'h2E;

  // Input function codes
  localparam logic        FUNC_WRITE   = 1'b0;
  localparam logic        FUNC_DECODE  = 1'b1;

  // Reset value of the hop limit register
  localparam logic [4:0]  HOPS_RESET   = 5'd8;

  // Completion status of a decode
  typedef enum logic [1:0] {
    NS_OK        = 2'd0,
    NS_HOP_LIMIT = 2'd1,
    NS_TOO_LONG  = 2'd2
  } name_status_t;

  // Controller states
  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_HEAD   = 6'b000100,
    S_PTR    = 6'b001000,
    S_LABEL  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic         clear_wr;     // write zero at the sweep address, advance
    logic         load_wr;      // store the input byte
    logic         start;        // begin a walk at the input offset
    logic         hop;          // take the first pointer byte
    logic         jump;         // take the second pointer byte, jump
    logic         label_start;  // take a label length byte
    logic         put_dot;      // append a separator
    logic         put_char;     // append the current label byte
    logic         end_walk;     // latch the completion status
    name_status_t end_code;
    logic         emit_final;   // push the final group
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic byte_zero;
    logic byte_ptr;
    logic hop_limit;
    logic name_full;
    logic label_done;
    logic dot_pend;
    logic put_ok;
    logic out_free;
    logic clear_done;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/dnd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dnd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/core/dnd_ctrl.sv]
// Controller state machine for the DNS name walk.
`default_nettype none

module dnd_ctrl import dnd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_func,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Sequence the walk
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.end_code = NS_OK;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_DECODE) begin
            cmd.start  = 1'b1;
            state_next = S_HEAD;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_HEAD: begin
        if (sts.byte_zero) begin
          cmd.end_walk = 1'b1;
          cmd.end_code = NS_OK;
          state_next   = S_FINISH;
        end else if (sts.byte_ptr) begin
          if (sts.hop_limit) begin
            cmd.end_walk = 1'b1;
            cmd.end_code = NS_HOP_LIMIT;
            state_next   = S_FINISH;
          end else begin
            cmd.hop    = 1'b1;
            state_next = S_PTR;
          end
        end else if (sts.dot_pend) begin
          if (sts.name_full) begin
            cmd.end_walk = 1'b1;
            cmd.end_code = NS_TOO_LONG;
            state_next   = S_FINISH;
          end else if (sts.put_ok) begin
            cmd.put_dot     = 1'b1;
            cmd.label_start = 1'b1;
            state_next      = S_LABEL;
          end
        end else begin
          cmd.label_start = 1'b1;
          state_next      = S_LABEL;
        end
      end
      S_PTR: begin
        cmd.jump   = 1'b1;
        state_next = S_HEAD;
      end
      S_LABEL: begin
        if (sts.name_full) begin
          cmd.end_walk = 1'b1;
          cmd.end_code = NS_TOO_LONG;
          state_next   = S_FINISH;
        end else if (sts.put_ok) begin
          cmd.put_char = 1'b1;
          if (sts.label_done) begin
            state_next = S_HEAD;
          end
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/dnd_datapath.sv]
// Datapath: packet store, walk registers, character packer and output register.
`default_nettype none

module dnd_datapath import dnd_pkg::*; #(
  parameter int MAX_NAME_CHARS = 255
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [4:0]        cfg_wr_data,
  input  wire logic [ADDR_W-1:0] in_offset,
  input  wire logic [7:0]        in_data,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [31:0]            out_chars,
  output logic [2:0]             out_count,
  output logic                   out_last,
  output name_status_t           out_status
);

  localparam logic [7:0] NAME_LIMIT = 8'(MAX_NAME_CHARS);

  logic [ADDR_W-1:0] read_index, read_index_next;
  logic [4:0]        max_hops;
  logic [4:0]        hops_taken;
  logic [7:0]        chars_emitted;
  logic              dot_pending;
  logic [5:0]        label_left;
  logic [5:0]        ptr_hi;
  logic [31:0]       pack_buffer;
  logic [2:0]        pack_cnt;
  name_status_t      end_code;

  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [7:0]        ram_wr_data;
  logic [7:0]        rdata;
  logic [13:0]       ptr_target;
  logic              do_put;
  logic [7:0]        put_c;
  logic              push;
  logic              out_free;

  // Packet store; read address follows the next walk index
  assign ram_wr_en   = cmd.clear_wr | cmd.load_wr;
  assign ram_wr_addr = cmd.clear_wr ? read_index : in_offset;
  assign ram_wr_data = cmd.clear_wr ? 8'd0 : in_data;

  dnd_ram #(
    .WIDTH (8),
    .DEPTH (PACKET_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (read_index_next),
    .rd_data (rdata)
  );

  // Select the next walk index
  assign ptr_target = {ptr_hi, rdata};

  always_comb begin
    read_index_next = read_index;
    if (cmd.start) begin
      read_index_next = in_offset;
    end else if (cmd.jump) begin
      read_index_next = ptr_target[ADDR_W-1:0];
    end else if (cmd.clear_wr | cmd.hop | cmd.label_start | cmd.put_char) begin
      read_index_next = read_index + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_index <= '0;
    end else begin
      read_index <= read_index_next;
    end
  end

  // Hop limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_hops <= HOPS_RESET;
    end else if (cfg_wr_en) begin
      max_hops <= cfg_wr_data;
    end
  end

  assign do_put   = cmd.put_dot | cmd.put_char;
  assign put_c    = cmd.put_dot ? DOT_CHAR : rdata;
  assign out_free = !out_valid || out_ready;
  assign push     = (do_put && (pack_cnt == 3'd4)) || cmd.emit_final;

  // Track walk counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      hops_taken    <= '0;
      chars_emitted <= '0;
      dot_pending   <= 1'b0;
      label_left    <= '0;
      end_code      <= NS_OK;
    end else begin
      if (cmd.start) begin
        hops_taken <= '0;
      end else if (cmd.hop) begin
        hops_taken <= hops_taken + 1'b1;
      end
      if (cmd.start) begin
        chars_emitted <= '0;
      end else if (do_put) begin
        chars_emitted <= chars_emitted + 1'b1;
      end
      if (cmd.start || cmd.label_start) begin
        dot_pending <= 1'b0;
      end else if (cmd.put_char && (label_left == 6'd1)) begin
        dot_pending <= 1'b1;
      end
      if (cmd.label_start) begin
        label_left <= rdata[5:0];
      end else if (cmd.put_char) begin
        label_left <= label_left - 1'b1;
      end
      if (cmd.end_walk) begin
        end_code <= cmd.end_code;
      end
    end
  end

  // Hold the upper pointer bits
  always_ff @(posedge clk) begin
    if (cmd.hop) begin
      ptr_hi <= rdata[5:0];
    end
  end

  // Pack characters four to a group
  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      pack_buffer <= '0;
      pack_cnt    <= '0;
    end else if (do_put) begin
      if (pack_cnt == 3'd4) begin
        pack_buffer <= {24'd0, put_c};
        pack_cnt    <= 3'd1;
      end else begin
        pack_buffer[8*pack_cnt[1:0] +: 8] <= put_c;
        pack_cnt                          <= pack_cnt + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_chars  <= pack_buffer;
      out_count  <= pack_cnt;
      out_last   <= cmd.emit_final;
      out_status <= cmd.emit_final ? end_code : NS_OK;
    end
  end

  // Report status to the controller
  assign sts.byte_zero  = (rdata == 8'd0);
  assign sts.byte_ptr   = ((rdata & PTR_MARK) != 8'd0);
  assign sts.hop_limit  = (hops_taken >= max_hops);
  assign sts.name_full  = (chars_emitted >= NAME_LIMIT);
  assign sts.label_done = (label_left == 6'd1);
  assign sts.dot_pend   = dot_pending;
  assign sts.put_ok     = (pack_cnt != 3'd4) || out_free;
  assign sts.out_free   = out_free;
  assign sts.clear_done = (read_index == ADDR_W'(PACKET_BYTES - 1));

endmodule

`default_nettype wire

[rtl/core/dns_name_decompressor.sv]
// Top level of the DNS name decompressor: stream ports, controller and datapath.
// s_axis_tready stays high across packet byte writes, so writes run back to back.
// A decode starts, then reads each byte walked in turn (length byte, each label
// character, both pointer bytes, the byte that ends the walk) and then closes.
// Output stalls hold the walk; up to four characters a transaction come from one register.
// Reset is synchronous; after it a clearing pass zeroes all 512 bytes of the packet store.
`default_nettype none

module dns_name_decompressor import dnd_pkg::*; #(
  parameter int MAX_NAME_CHARS = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [4:0]  cfg_wr_data,   // max_pointer_hops
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // offset[8:0], data_byte[16:9], zero pad
  input  wire logic [0:0]  s_axis_tuser,  // func[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // name_chars[31:0], char_count[34:32], pad
  output logic             m_axis_tlast,
  output logic [1:0]       m_axis_tuser   // status[1:0]
);

  cmd_t         cmd;
  sts_t         sts;
  logic [31:0]  out_chars;
  logic [2:0]   out_count;
  name_status_t out_status;

  dnd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_func  (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dnd_datapath #(
    .MAX_NAME_CHARS (MAX_NAME_CHARS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_offset   (s_axis_tdata[ADDR_W-1:0]),
    .in_data     (s_axis_tdata[16:9]),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_chars   (out_chars),
    .out_count   (out_count),
    .out_last    (m_axis_tlast),
    .out_status  (out_status)
  );

  // Pack result fields
  assign m_axis_tdata = {5'd0, out_count, out_chars};
  assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

[rtl/core/dnd_checker.sv]
// Port-level assertions for the DNS name decompressor and their bind.
`default_nettype none

module dnd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic [1:0]  m_axis_tuser
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Only the final transaction may be partial or carry a status
  a_mid_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[34:32] == 3'd4 && m_axis_tuser == 2'd0)
    else $error("non-final result not a full ok group");

  // Unused character lanes are zero
  a_lanes_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[34:32] >= 3'd1 || m_axis_tdata[7:0] == 8'd0)
      && (m_axis_tdata[34:32] >= 3'd2 || m_axis_tdata[15:8] == 8'd0)
      && (m_axis_tdata[34:32] >= 3'd3 || m_axis_tdata[23:16] == 8'd0)
      && (m_axis_tdata[34:32] >= 3'd4 || m_axis_tdata[31:24] == 8'd0))
    else $error("character lane beyond count not zero");

  // Store clearing blocks input right after reset
  a_clear_block: assert property (@(posedge clk)
    rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("input accepted during clearing pass");

endmodule

bind dns_name_decompressor dnd_checker u_dnd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
